/* rtl/dlkl_pkg.sv */
// dlkl_pkg: sizes, item types, codes and sequencer states of the doubly linked key list
// no dependencies; imported by dlkl_ram users and doubly_linked_key_list
package dlkl_pkg;

    localparam int POOL_DEPTH  = 16;
    localparam int KEY_BITS    = 32;
    localparam int IDX_BITS    = $clog2(POOL_DEPTH);
    localparam int CNT_BITS    = $clog2(POOL_DEPTH + 1);
    localparam int KEY_IN_BITS = 32;
    localparam int OPCODE_BITS = 2;
    localparam int STATUS_BITS = 2;
    localparam int ENTRY_BITS  = 5;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_INS_BACK  = 2'd0,
        OP_INS_FRONT = 2'd1,
        OP_DELETE    = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INS_NODE,
        ST_INS_LINK,
        ST_WALK,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [OPCODE_BITS-1:0]        opcode;
        logic signed [KEY_IN_BITS-1:0] key;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [ENTRY_BITS-1:0]  entry_count;
    } rsp_item_t;

endpackage

/* rtl/doubly_linked_key_list.sv */
// doubly_linked_key_list: key list in a node pool with forward and backward links
// depends on dlkl_pkg and dlkl_ram (key, forward link and backward link stores)
// insert steps: free node scan, node write, link write (skipped on an empty list), result
// delete: one node compared per cycle from the key ram reads, walking the forward links
// one item at a time; a new item is taken while the previous result waits in the output register
// reset: list empty, all nodes free, no result pending; node stores are not cleared
module doubly_linked_key_list (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  dlkl_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output dlkl_pkg::rsp_item_t rsp
);

    import dlkl_pkg::*;

    state_t                 state_reg, state_next;
    logic [OPCODE_BITS-1:0] op_reg, op_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [IDX_BITS-1:0]    head_reg, head_next;
    logic [IDX_BITS-1:0]    tail_reg, tail_next;
    logic [IDX_BITS-1:0]    node_reg, node_next;
    logic [IDX_BITS-1:0]    link_reg, link_next;
    logic [IDX_BITS-1:0]    p_reg, p_next;
    logic [IDX_BITS-1:0]    scan_reg, scan_next;
    logic [CNT_BITS-1:0]    left_reg, left_next;
    logic [CNT_BITS-1:0]    live_reg, live_next;
    logic [POOL_DEPTH-1:0]  free_reg, free_next;
    status_t                stat_reg, stat_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_item_t              rsp_reg, rsp_next;

    logic [IDX_BITS-1:0] rd_addr;
    logic [KEY_BITS-1:0] key_rdata;
    logic [IDX_BITS-1:0] fwd_rdata;
    logic [IDX_BITS-1:0] bwd_rdata;
    logic                key_we, fwd_we, bwd_we;
    logic [IDX_BITS-1:0] key_waddr, fwd_waddr, bwd_waddr;
    logic [KEY_BITS-1:0] key_wdata;
    logic [IDX_BITS-1:0] fwd_wdata, bwd_wdata;

    dlkl_ram #(.WIDTH(KEY_BITS), .DEPTH(POOL_DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (rd_addr),
        .rdata (key_rdata)
    );

    dlkl_ram #(.WIDTH(IDX_BITS), .DEPTH(POOL_DEPTH)) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (fwd_waddr),
        .wdata (fwd_wdata),
        .raddr (rd_addr),
        .rdata (fwd_rdata)
    );

    dlkl_ram #(.WIDTH(IDX_BITS), .DEPTH(POOL_DEPTH)) u_bwd_ram (
        .clk   (clk),
        .we    (bwd_we),
        .waddr (bwd_waddr),
        .wdata (bwd_wdata),
        .raddr (rd_addr),
        .rdata (bwd_rdata)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            live_reg      <= '0;
            free_reg      <= '1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            live_reg      <= live_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        node_reg <= node_next;
        link_reg <= link_next;
        p_reg    <= p_next;
        scan_reg <= scan_next;
        left_reg <= left_next;
        stat_reg <= stat_next;
        rsp_reg  <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        node_next      = node_reg;
        link_next      = link_reg;
        p_next         = p_reg;
        scan_next      = scan_reg;
        left_next      = left_reg;
        live_next      = live_reg;
        free_next      = free_reg;
        stat_next      = stat_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        rd_addr   = head_reg;
        key_we    = 1'b0;
        fwd_we    = 1'b0;
        bwd_we    = 1'b0;
        key_waddr = node_reg;
        fwd_waddr = node_reg;
        bwd_waddr = node_reg;
        key_wdata = key_reg;
        fwd_wdata = node_reg;
        bwd_wdata = node_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next  = req.opcode;
                    key_next = KEY_BITS'(req.key);
                    case (req.opcode)
                        OP_INS_BACK, OP_INS_FRONT:
                        begin
                            if (live_reg == CNT_BITS'(POOL_DEPTH))
                            begin
                                stat_next  = STAT_FULL;
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                scan_next  = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (live_reg == '0)
                            begin
                                stat_next  = STAT_NOT_FOUND;
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                p_next     = head_reg;
                                left_next  = live_reg;
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            stat_next  = STAT_DONE;
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (free_reg[scan_reg])
                begin
                    node_next  = scan_reg;
                    state_next = ST_INS_NODE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_INS_NODE:
            begin
                key_we              = 1'b1;
                fwd_we              = 1'b1;
                bwd_we              = 1'b1;
                free_next[node_reg] = 1'b0;
                live_next           = live_reg + 1'b1;
                if (live_reg == '0)
                begin
                    head_next  = node_reg;
                    tail_next  = node_reg;
                    stat_next  = STAT_DONE;
                    state_next = ST_RESP;
                end
                else if (op_reg == OP_INS_FRONT)
                begin
                    fwd_wdata  = head_reg;
                    link_next  = head_reg;
                    head_next  = node_reg;
                    state_next = ST_INS_LINK;
                end
                else
                begin
                    bwd_wdata  = tail_reg;
                    link_next  = tail_reg;
                    tail_next  = node_reg;
                    state_next = ST_INS_LINK;
                end
            end
            ST_INS_LINK:
            begin
                if (op_reg == OP_INS_FRONT)
                begin
                    bwd_we    = 1'b1;
                    bwd_waddr = link_reg;
                end
                else
                begin
                    fwd_we    = 1'b1;
                    fwd_waddr = link_reg;
                end
                stat_next  = STAT_DONE;
                state_next = ST_RESP;
            end
            ST_WALK:
            begin
                if (key_rdata == key_reg)
                begin
                    free_next[p_reg] = 1'b1;
                    live_next        = live_reg - 1'b1;
                    stat_next        = STAT_DONE;
                    state_next       = ST_RESP;
                    if ((p_reg == head_reg) && (p_reg == tail_reg))
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else if (p_reg == head_reg)
                    begin
                        head_next = fwd_rdata;
                        bwd_we    = 1'b1;
                        bwd_waddr = fwd_rdata;
                        bwd_wdata = fwd_rdata;
                    end
                    else if (p_reg == tail_reg)
                    begin
                        tail_next = bwd_rdata;
                        fwd_we    = 1'b1;
                        fwd_waddr = bwd_rdata;
                        fwd_wdata = bwd_rdata;
                    end
                    else
                    begin
                        fwd_we    = 1'b1;
                        fwd_waddr = bwd_rdata;
                        fwd_wdata = fwd_rdata;
                        bwd_we    = 1'b1;
                        bwd_waddr = fwd_rdata;
                        bwd_wdata = bwd_rdata;
                    end
                end
                else if (left_reg == CNT_BITS'(1))
                begin
                    stat_next  = STAT_NOT_FOUND;
                    state_next = ST_RESP;
                end
                else
                begin
                    p_next    = fwd_rdata;
                    rd_addr   = fwd_rdata;
                    left_next = left_reg - 1'b1;
                end
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = stat_reg;
                    rsp_next.entry_count = ENTRY_BITS'(live_reg);
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CNT_BITS'(POOL_DEPTH))
        else $error("entry count above pool depth");

    a_free_matches_live: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(free_reg) == (POOL_DEPTH - int'(live_reg)))
        else $error("free map disagrees with entry count");

    a_rsp_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result raised outside response state");

    a_walk_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (left_reg != '0))
        else $error("walk running with no nodes left");

    a_insert_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (live_reg != CNT_BITS'(POOL_DEPTH)))
        else $error("free node scan on a full pool");
`endif

endmodule

/* rtl/dlkl_ram.sv */
// dlkl_ram: generic single write port, single read port ram with registered read
// no dependencies
module dlkl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
